### sv/lcd_rect_fill_command_stream_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle fill command stream unit
// Shared helpers that wrap a clocked property with reset gating.
// ----------------------------------------------------------------------------
`ifndef LCD_RECT_FILL_COMMAND_STREAM_UNIT_DEFINES_SVH
`define LCD_RECT_FILL_COMMAND_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LCDRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LCDRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lcdrf_pkg.sv
// ----------------------------------------------------------------------------
// lcdrf_pkg
// Types and constants shared by the rectangle fill command stream unit.
// ----------------------------------------------------------------------------
package lcdrf_pkg;

	// Controller command bytes
	localparam logic [7:0] CMD_COLUMN = 8'h2A;
	localparam logic [7:0] CMD_ROW    = 8'h2B;
	localparam logic [7:0] CMD_WRITE  = 8'h2C;

	// Configuration register indexes
	localparam logic [1:0] REG_PANEL_WIDTH   = 2'd0;
	localparam logic [1:0] REG_PANEL_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
	localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

	// Configuration reset values
	localparam logic [8:0] RST_PANEL_WIDTH   = 9'd128;
	localparam logic [8:0] RST_PANEL_HEIGHT  = 9'd128;
	localparam logic [7:0] RST_COLUMN_OFFSET = 8'd2;
	localparam logic [7:0] RST_ROW_OFFSET    = 8'd1;

	// Operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Header step positions; pixel phase follows the last command
	localparam logic [3:0] HDR_CMD_COL      = 4'd0;
	localparam logic [3:0] HDR_COL_START_HI = 4'd1;
	localparam logic [3:0] HDR_COL_START_LO = 4'd2;
	localparam logic [3:0] HDR_COL_END_HI   = 4'd3;
	localparam logic [3:0] HDR_COL_END_LO   = 4'd4;
	localparam logic [3:0] HDR_CMD_ROW      = 4'd5;
	localparam logic [3:0] HDR_ROW_START_HI = 4'd6;
	localparam logic [3:0] HDR_ROW_START_LO = 4'd7;
	localparam logic [3:0] HDR_ROW_END_HI   = 4'd8;
	localparam logic [3:0] HDR_ROW_END_LO   = 4'd9;
	localparam logic [3:0] HDR_CMD_WRITE    = 4'd10;
	localparam logic [3:0] HDR_PIXELS       = 4'd11;

	// Classified request as it travels through the queue
	typedef struct packed {
		logic        is_tick;
		logic        origin_ok;
		logic [15:0] col_start;
		logic [15:0] col_end;
		logic [15:0] row_start;
		logic [15:0] row_end;
		logic [15:0] color;
	} req_t;

endpackage

### sv/lcdrf_front.sv
// ----------------------------------------------------------------------------
// lcdrf_front
// Holds configuration, classifies items and clips fill requests to the panel.
// ----------------------------------------------------------------------------
module lcdrf_front #(
	parameter int MAX_SIDE = 256,
	parameter int SIDE_W   = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [15:0]         rect_x,
	input  logic [15:0]         rect_y,
	input  logic [15:0]         rect_width,
	input  logic [15:0]         rect_height,
	input  logic [15:0]         fill_color,
	input  logic                q_full,
	output logic                push,
	output lcdrf_pkg::req_t     req,
	output logic [SIDE_W-1:0]   clip_w,
	output logic [SIDE_W-1:0]   clip_h
);
	import lcdrf_pkg::*;

	logic [8:0]  panel_width_q;
	logic [8:0]  panel_height_q;
	logic [7:0]  column_offset_q;
	logic [7:0]  row_offset_q;

	logic [15:0] pw;
	logic [15:0] ph;
	logic [16:0] x_end;
	logic [16:0] y_end;
	logic [15:0] w_c;
	logic [15:0] h_c;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q   <= RST_PANEL_WIDTH;
			panel_height_q  <= RST_PANEL_HEIGHT;
			column_offset_q <= RST_COLUMN_OFFSET;
			row_offset_q    <= RST_ROW_OFFSET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PANEL_WIDTH:   panel_width_q   <= cfg_data;
				REG_PANEL_HEIGHT:  panel_height_q  <= cfg_data;
				REG_COLUMN_OFFSET: column_offset_q <= cfg_data[7:0];
				REG_ROW_OFFSET:    row_offset_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stall while the queue has no room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Limit panel size to the largest supported side
	assign pw = ({7'd0, panel_width_q} > 16'(MAX_SIDE)) ? 16'(MAX_SIDE) : {7'd0, panel_width_q};
	assign ph = ({7'd0, panel_height_q} > 16'(MAX_SIDE)) ? 16'(MAX_SIDE)
		: {7'd0, panel_height_q};

	// Clip each side at the panel edge
	assign x_end = {1'b0, rect_x} + {1'b0, rect_width};
	assign y_end = {1'b0, rect_y} + {1'b0, rect_height};
	assign w_c   = (x_end > {1'b0, pw}) ? (pw - rect_x) : rect_width;
	assign h_c   = (y_end > {1'b0, ph}) ? (ph - rect_y) : rect_height;

	assign clip_w = w_c[SIDE_W-1:0];
	assign clip_h = h_c[SIDE_W-1:0];

	// Build window coordinates; end lies one below start when a side is zero
	always_comb begin
		req.is_tick   = (operation == OP_TICK);
		req.origin_ok = (rect_x < pw) && (rect_y < ph);
		req.col_start = rect_x + {8'd0, column_offset_q};
		req.col_end   = rect_x + w_c - 16'd1 + {8'd0, column_offset_q};
		req.row_start = rect_y + {8'd0, row_offset_q};
		req.row_end   = rect_y + h_c - 16'd1 + {8'd0, row_offset_q};
		req.color     = fill_color;
	end

endmodule

### sv/lcdrf_queue.sv
// ----------------------------------------------------------------------------
// lcdrf_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`include "lcd_rect_fill_command_stream_unit_defines.svh"

module lcdrf_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              pop,
	output logic [DATA_W-1:0] rd_data,
	output logic              not_empty,
	output logic              full
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = slot_q[rd_ptr_q];

	// Store an entry on push
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`LCDRF_ASSERT_NOW(a_no_push_full, clk, arst_n, full, !push, "push into a full queue")
	`LCDRF_ASSERT_NOW(a_no_pop_empty, clk, arst_n, !not_empty, !pop, "pop from an empty queue")
	`LCDRF_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push, count_q == $past(count_q) - CNT_W'(1), "occupancy did not drop on pop")

endmodule

### sv/lcdrf_back.sv
// ----------------------------------------------------------------------------
// lcdrf_back
// Executes queued requests and emits the command and pixel byte stream.
// ----------------------------------------------------------------------------
`include "lcd_rect_fill_command_stream_unit_defines.svh"

module lcdrf_back #(
	parameter int SIDE_W = 9,
	parameter int CNT_W  = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  lcdrf_pkg::req_t   head,
	input  logic [SIDE_W-1:0] head_w,
	input  logic [SIDE_W-1:0] head_h,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              is_command,
	output logic              last_byte
);
	import lcdrf_pkg::*;

	logic              busy_q;
	logic [3:0]        step_q;
	logic              low_q;
	logic [CNT_W-1:0]  pixels_q;
	logic [15:0]       col_start_q;
	logic [15:0]       col_end_q;
	logic [15:0]       row_start_q;
	logic [15:0]       row_end_q;
	logic [15:0]       color_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              is_command_q;
	logic              last_byte_q;

	logic              out_ready;
	logic              pop_tick;
	logic              pop_start;
	logic              emit;
	logic [7:0]        hdr_byte;
	logic              hdr_cmd;
	logic [2*SIDE_W-1:0] pix_prod;

	// Pop starts at once; ticks wait for room in the output register
	assign out_ready = !out_valid_q || !out_stall;
	assign pop       = head_valid && (!head.is_tick || out_ready);
	assign pop_tick  = pop && head.is_tick;
	assign pop_start = pop && !head.is_tick;
	assign emit      = pop_tick && busy_q;
	assign pix_prod  = head_w * head_h;

	// Select the header byte for the current step
	always_comb begin
		hdr_cmd  = 1'b0;
		hdr_byte = 8'h00;
		unique case (step_q)
			HDR_CMD_COL:      begin hdr_byte = CMD_COLUMN; hdr_cmd = 1'b1; end
			HDR_COL_START_HI: hdr_byte = col_start_q[15:8];
			HDR_COL_START_LO: hdr_byte = col_start_q[7:0];
			HDR_COL_END_HI:   hdr_byte = col_end_q[15:8];
			HDR_COL_END_LO:   hdr_byte = col_end_q[7:0];
			HDR_CMD_ROW:      begin hdr_byte = CMD_ROW; hdr_cmd = 1'b1; end
			HDR_ROW_START_HI: hdr_byte = row_start_q[15:8];
			HDR_ROW_START_LO: hdr_byte = row_start_q[7:0];
			HDR_ROW_END_HI:   hdr_byte = row_end_q[15:8];
			HDR_ROW_END_LO:   hdr_byte = row_end_q[7:0];
			HDR_CMD_WRITE:    begin hdr_byte = CMD_WRITE; hdr_cmd = 1'b1; end
			default:          hdr_byte = 8'h00;
		endcase
	end

	// Latch the window on an accepted start
	always_ff @(posedge clk) begin
		if (pop_start && !busy_q && head.origin_ok) begin
			col_start_q <= head.col_start;
			col_end_q   <= head.col_end;
			row_start_q <= head.row_start;
			row_end_q   <= head.row_end;
			color_q     <= head.color;
		end
	end

	// Sequence header, then pixel pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= HDR_CMD_COL;
			low_q    <= 1'b0;
			pixels_q <= '0;
		end else if (pop_start && !busy_q && head.origin_ok) begin
			busy_q   <= 1'b1;
			step_q   <= HDR_CMD_COL;
			low_q    <= 1'b0;
			pixels_q <= pix_prod[CNT_W-1:0];
		end else if (emit) begin
			if (step_q != HDR_PIXELS) begin
				step_q <= step_q + 4'd1;
				if (step_q == HDR_CMD_WRITE && pixels_q == '0) begin
					busy_q <= 1'b0;
					step_q <= HDR_CMD_COL;
				end
			end else if (!low_q) begin
				low_q <= 1'b1;
			end else begin
				low_q    <= 1'b0;
				pixels_q <= pixels_q - CNT_W'(1);
				if (pixels_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					step_q <= HDR_CMD_COL;
				end
			end
		end
	end

	// Output register: load on a productive tick, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (step_q != HDR_PIXELS) begin
				out_byte_q   <= hdr_byte;
				is_command_q <= hdr_cmd;
				last_byte_q  <= (step_q == HDR_CMD_WRITE) && (pixels_q == '0);
			end else begin
				out_byte_q   <= low_q ? color_q[7:0] : color_q[15:8];
				is_command_q <= 1'b0;
				last_byte_q  <= low_q && (pixels_q == CNT_W'(1));
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_command = is_command_q;
	assign last_byte  = last_byte_q;

	`LCDRF_ASSERT_NOW(a_idle_clean, clk, arst_n, !busy_q, step_q == HDR_CMD_COL && !low_q, "idle with stale sequence state")
	`LCDRF_ASSERT_NOW(a_low_in_pixels, clk, arst_n, low_q, step_q == HDR_PIXELS, "low half outside pixel phase")
	`LCDRF_ASSERT_NOW(a_pixels_left, clk, arst_n, busy_q && step_q == HDR_PIXELS, pixels_q != '0, "pixel phase with no pixels left")

endmodule

### sv/lcd_rect_fill_command_stream_unit.sv
// ----------------------------------------------------------------------------
// lcd_rect_fill_command_stream_unit
// Streams window and fill commands for a serial TFT controller (RGB565).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries items: operation 0 is a fill
//   request (origin, size, colour), operation 1 is a tick asking for the next
//   byte. Requests off the panel, or arriving while a stream runs, are dropped.
//   Output channel (out_valid/out_stall) carries one byte per productive tick
//   with its command flag and a last flag on the stream's final byte.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Timing:
//   One item is taken every cycle while the queue has room. A tick's byte
//   passes through the queue and then the output register before it shows
//   on the output. The back end's one-entry-per-cycle pop from the queue,
//   held only while a tick waits on a stalled output, sets that rate.
// Stalls:
//   A stalled output holds its byte; ticks then wait in the queue and the
//   input stalls only once the queue is full. Start requests never wait on
//   the output.
// Reset:
//   Clears the queue, the stream state and the output valid; configuration
//   returns to a 128 by 128 panel with offsets 2 and 1.
// ----------------------------------------------------------------------------
module lcd_rect_fill_command_stream_unit #(
	parameter int MAX_SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [15:0] rect_x,
	input  logic [15:0] rect_y,
	input  logic [15:0] rect_width,
	input  logic [15:0] rect_height,
	input  logic [15:0] fill_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        is_command,
	output logic        last_byte
);
	import lcdrf_pkg::*;

	localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
	localparam int CNT_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int ENTRY_W = $bits(req_t) + 2 * SIDE_W;
	localparam int Q_DEPTH = 4;

	req_t              f_req;
	logic [SIDE_W-1:0] f_w;
	logic [SIDE_W-1:0] f_h;
	logic              push;
	logic              q_full;
	logic              q_not_empty;
	logic              pop;
	logic [ENTRY_W-1:0] q_rd;
	req_t              b_req;
	logic [SIDE_W-1:0] b_w;
	logic [SIDE_W-1:0] b_h;

	lcdrf_front #(
		.MAX_SIDE (MAX_SIDE),
		.SIDE_W   (SIDE_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.fill_color  (fill_color),
		.q_full      (q_full),
		.push        (push),
		.req         (f_req),
		.clip_w      (f_w),
		.clip_h      (f_h)
	);

	lcdrf_queue #(
		.DATA_W (ENTRY_W),
		.DEPTH  (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   ({f_req, f_w, f_h}),
		.pop       (pop),
		.rd_data   (q_rd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	assign {b_req, b_w, b_h} = q_rd;

	lcdrf_back #(
		.SIDE_W (SIDE_W),
		.CNT_W  (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (b_req),
		.head_w     (b_w),
		.head_h     (b_h),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_command (is_command),
		.last_byte  (last_byte)
	);

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: rectangle fill command stream unit testbench
// Drives fill requests and byte ticks through the valid/stall input channel,
// predicts every output byte (window commands, bounds, colour pairs, last
// flag) and compares each output transfer against the oldest prediction.
// Runs several panel/offset settings with varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdrf_pkg::*;

	localparam int MAX_SIDE     = 256;
	localparam int TIMEOUT_NS   = 3000000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [7:0] data;
		logic       cmd;
		logic       last;
	} lcd_byte_t;

	// Tracks the stream state and the bytes still owed by the block
	class fill_byte_tracker;
		bit [8:0]  panel_w;
		bit [8:0]  panel_h;
		bit [7:0]  col_off;
		bit [7:0]  row_off;
		bit        streaming;
		bit [3:0]  hdr_pos;
		bit [15:0] bounds [4];
		bit [15:0] color;
		bit [16:0] pix_left;
		bit        low_next;
		lcd_byte_t expected_bytes [$];
		int        errors;

		function new();
			panel_w   = RST_PANEL_WIDTH;
			panel_h   = RST_PANEL_HEIGHT;
			col_off   = RST_COLUMN_OFFSET;
			row_off   = RST_ROW_OFFSET;
			streaming = 1'b0;
			hdr_pos   = HDR_CMD_COL;
			color     = '0;
			pix_left  = '0;
			low_next  = 1'b0;
			errors    = 0;
			foreach (bounds[i]) bounds[i] = '0;
		endfunction

		function int eff_width();
			return (panel_w > MAX_SIDE) ? MAX_SIDE : int'(panel_w);
		endfunction

		function int eff_height();
			return (panel_h > MAX_SIDE) ? MAX_SIDE : int'(panel_h);
		endfunction

		function void write_reg(logic [1:0] idx, logic [8:0] val);
			case (idx)
				REG_PANEL_WIDTH:   panel_w = val;
				REG_PANEL_HEIGHT:  panel_h = val;
				REG_COLUMN_OFFSET: col_off = val[7:0];
				REG_ROW_OFFSET:    row_off = val[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// Advance the stream by one accepted item
		function void note_item(logic op, logic [15:0] x, logic [15:0] y,
				logic [15:0] w, logic [15:0] h, logic [15:0] c);
			int        epw;
			int        eph;
			int        xi;
			int        yi;
			int        wi;
			int        hi;
			lcd_byte_t nb;
			if (op == OP_START) begin
				epw = eff_width();
				eph = eff_height();
				xi  = x;
				yi  = y;
				wi  = w;
				hi  = h;
				// drop while busy or with the origin off the panel
				if (streaming) return;
				if (xi >= epw || yi >= eph) return;
				if (xi + wi > epw) wi = epw - xi;
				if (yi + hi > eph) hi = eph - yi;
				bounds[0] = 16'(xi + int'(col_off));
				bounds[1] = 16'(xi + wi - 1 + int'(col_off));
				bounds[2] = 16'(yi + int'(row_off));
				bounds[3] = 16'(yi + hi - 1 + int'(row_off));
				color     = c;
				pix_left  = 17'(wi * hi);
				low_next  = 1'b0;
				hdr_pos   = HDR_CMD_COL;
				streaming = 1'b1;
			end else begin
				if (!streaming) return;
				nb = '0;
				if (hdr_pos < HDR_PIXELS) begin
					case (hdr_pos)
						HDR_CMD_COL: begin
							nb.data = CMD_COLUMN;
							nb.cmd  = 1'b1;
						end
						HDR_COL_START_HI: nb.data = bounds[0][15:8];
						HDR_COL_START_LO: nb.data = bounds[0][7:0];
						HDR_COL_END_HI:   nb.data = bounds[1][15:8];
						HDR_COL_END_LO:   nb.data = bounds[1][7:0];
						HDR_CMD_ROW: begin
							nb.data = CMD_ROW;
							nb.cmd  = 1'b1;
						end
						HDR_ROW_START_HI: nb.data = bounds[2][15:8];
						HDR_ROW_START_LO: nb.data = bounds[2][7:0];
						HDR_ROW_END_HI:   nb.data = bounds[3][15:8];
						HDR_ROW_END_LO:   nb.data = bounds[3][7:0];
						HDR_CMD_WRITE: begin
							nb.data = CMD_WRITE;
							nb.cmd  = 1'b1;
						end
						default: ;
					endcase
					hdr_pos++;
					// an empty window ends on the write command
					if (hdr_pos == HDR_PIXELS && pix_left == 0) nb.last = 1'b1;
				end else if (!low_next) begin
					nb.data  = color[15:8];
					low_next = 1'b1;
				end else begin
					nb.data  = color[7:0];
					low_next = 1'b0;
					if (pix_left != 0) pix_left--;
					if (pix_left == 0) nb.last = 1'b1;
				end
				if (nb.last) begin
					streaming = 1'b0;
					hdr_pos   = HDR_CMD_COL;
					low_next  = 1'b0;
				end
				expected_bytes.push_back(nb);
			end
		endfunction

		task report(string msg);
			if (errors < 100) $display("%0t ns: %s", $time, msg);
			errors++;
		endtask

		// Compare one output transfer with the oldest owed byte
		task check_byte(logic [7:0] data, logic cmd, logic last);
			lcd_byte_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte %h cmd %b last %b", data, cmd, last));
				return;
			end
			want = expected_bytes.pop_front();
			if (data !== want.data)
				report($sformatf("out_byte %h, want %h", data, want.data));
			if (cmd !== want.cmd)
				report($sformatf("is_command %b, want %b (byte %h)", cmd, want.cmd, want.data));
			if (last !== want.last)
				report($sformatf("last_byte %b, want %b (byte %h)", last, want.last, want.data));
		endtask
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_write   = 1'b0;
	logic [1:0]  cfg_index   = '0;
	logic [8:0]  cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic        operation   = 1'b0;
	logic [15:0] rect_x      = '0;
	logic [15:0] rect_y      = '0;
	logic [15:0] rect_width  = '0;
	logic [15:0] rect_height = '0;
	logic [15:0] fill_color  = '0;
	logic        out_stall   = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        is_command;
	logic        last_byte;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;
	int useful_items  = 0;

	fill_byte_tracker tracker = new();

	lcd_rect_fill_command_stream_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_width (rect_width),
		.rect_height(rect_height),
		.fill_color (fill_color),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_command (is_command),
		.last_byte  (last_byte)
	);

	always #1 clk = ~clk;

	// Receiver: long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_byte(out_byte, is_command, last_byte);
	end

	// Offer one item and hold it until the transfer
	task automatic send_item(logic op, logic [15:0] x, logic [15:0] y,
			logic [15:0] w, logic [15:0] h, logic [15:0] c);
		bit was_streaming;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		rect_x      <= x;
		rect_y      <= y;
		rect_width  <= w;
		rect_height <= h;
		fill_color  <= c;
		do @(posedge clk); while (in_stall);
		was_streaming = tracker.streaming;
		tracker.note_item(op, x, y, w, h, c);
		if ((op == OP_TICK && was_streaming) ||
				(op == OP_START && !was_streaming && tracker.streaming))
			useful_items++;
	endtask

	task automatic send_tick();
		send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic noise_item();
		send_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// Tick until the current stream ends, with an occasional start while busy
	task automatic drain_stream();
		while (tracker.streaming) begin
			if ($urandom_range(99) < 4)
				send_item(OP_START, 16'($urandom_range(3)), 16'($urandom_range(3)),
					16'($urandom), 16'($urandom), 16'($urandom));
			send_tick();
		end
	endtask

	task automatic fill_rect(logic [15:0] x, logic [15:0] y, logic [15:0] w,
			logic [15:0] h, logic [15:0] c);
		send_item(OP_START, x, y, w, h, c);
		drain_stream();
	endtask

	function automatic int rand_side();
		int r;
		r = $urandom_range(99);
		if (r < 65) return $urandom_range(4);
		if (r < 95) return $urandom_range(12, 5);
		return $urandom_range(65535);
	endfunction

	// One well-formed request with its origin inside the panel, then its whole stream
	task automatic random_fill();
		int epw;
		int eph;
		int xi;
		int yi;
		int wi;
		int hi;
		epw = tracker.eff_width();
		eph = tracker.eff_height();
		if (epw == 0 || eph == 0) begin
			noise_item();
			return;
		end
		xi = $urandom_range(1) ? int'($urandom_range(epw - 1))
			: epw - 1 - int'($urandom_range((epw > 4) ? 3 : epw - 1));
		yi = $urandom_range(1) ? int'($urandom_range(eph - 1))
			: eph - 1 - int'($urandom_range((eph > 4) ? 3 : eph - 1));
		wi = rand_side();
		hi = (wi > 12) ? int'($urandom_range(1)) : rand_side();
		fill_rect(16'(xi), 16'(yi), 16'(wi), 16'(hi), 16'($urandom));
		if ($urandom_range(99) < 5) send_tick();
	endtask

	task automatic random_phase(int target);
		useful_items = 0;
		while (useful_items < target) begin
			if ($urandom_range(99) < 85) random_fill();
			else noise_item();
		end
	endtask

	// Edges of the panel, empty window, clipping, drops and starts while busy
	task automatic directed_set();
		int epw;
		int eph;
		epw = tracker.eff_width();
		eph = tracker.eff_height();
		send_tick();
		send_item(OP_START, 16'(epw), 16'd0, 16'd4, 16'd4, 16'h1234);
		send_item(OP_START, 16'd0, 16'(eph), 16'd4, 16'd4, 16'h4321);
		send_tick();
		fill_rect(16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
		fill_rect(16'(epw - 1), 16'(eph - 1), 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_START, 16'd0, 16'd0, 16'd3, 16'd2, 16'hA55A);
		send_tick();
		send_item(OP_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h0F0F);
		drain_stream();
		send_tick();
	endtask

	task automatic write_config(logic [8:0] pw, logic [8:0] ph, logic [8:0] co,
			logic [8:0] ro);
		logic [1:0] idx [4];
		logic [8:0] val [4];
		idx = '{REG_PANEL_WIDTH, REG_PANEL_HEIGHT, REG_COLUMN_OFFSET, REG_ROW_OFFSET};
		val = '{pw, ph, co, ro};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			tracker.write_reg(idx[i], val[i]);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Finish the stream, drop idling and let the block go quiet
	task automatic settle();
		drain_stream();
		in_valid      <= 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset configuration, no idling
		directed_set();
		// Hold the output off while ticks keep coming, so the input backs up
		hold_left = 400;
		fill_rect(16'd0, 16'd0, 16'd8, 16'd8, 16'($urandom));
		// Pause the sender until every byte is out
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		random_phase(150);
		settle();

		// Smallest panel, largest offsets, sender idling
		write_config(9'd1, 9'd1, 9'h1FF, 9'd255);
		send_idle_pct = 53;
		directed_set();
		random_phase(150);
		settle();

		// Full panel, zero offsets, receiver stalling
		write_config(9'd256, 9'd256, 9'd0, 9'd0);
		stall_pct = 53;
		directed_set();
		random_phase(150);
		settle();

		// Panel registers above the maximum side, both sides idling
		write_config(9'h1FF, 9'd300, 9'($urandom_range(255)), 9'($urandom_range(255)));
		send_idle_pct = 32;
		stall_pct     = 32;
		directed_set();
		random_phase(150);
		settle();

		// Zero width drops every request
		write_config(9'd0, 9'($urandom_range(511)), 9'($urandom_range(255)),
			9'($urandom_range(255)));
		send_idle_pct = 32;
		stall_pct     = 32;
		repeat (12) begin
			send_item(OP_START, 16'd0, 16'd0, 16'd2, 16'd2, 16'($urandom));
			send_tick();
		end
		settle();

		// Random panel and offsets
		write_config(9'($urandom_range(256, 1)), 9'($urandom_range(256, 1)),
			9'($urandom_range(255)), 9'($urandom_range(255)));
		send_idle_pct = 32;
		stall_pct     = 32;
		random_phase(150);
		settle();

		// Full panel with offsets that carry into the high byte: wide row clipped at the right edge
		write_config(9'd256, 9'd256, 9'd255, 9'd128);
		fill_rect(16'd192, 16'd255, 16'hFFFF, 16'hFFFF, 16'($urandom));
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0) begin
			$display("lcd_rect_fill_command_stream_unit verification clean");
		end else begin
			$display("lcd_rect_fill_command_stream_unit verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#TIMEOUT_NS;
		$display("lcd_rect_fill_command_stream_unit verification failed");
		$finish;
	end

endmodule
